FILE: hdl/lifn_pkg.sv
// ----------------------------------------------------------------------------
// lifn_pkg
// Shared widths, shift amounts, register codes and types for the encoded
// leaky integrate-and-fire neuron update pipeline.
// ----------------------------------------------------------------------------
package lifn_pkg;

  // Field widths
  localparam int IDX_W      = 8;
  localparam int DATA_W     = 32;
  localparam int INPUT_W    = 16;
  localparam int REFR_W     = 16;
  localparam int DECAY_W    = 16;
  localparam int CHIP_W     = 16;
  localparam int CORE_W     = 5;
  localparam int POP_W      = 11;
  localparam int TRACE_W    = 16;
  localparam int PROD_W     = DATA_W + INPUT_W;

  // Fixed-point shifts and key layout
  localparam int ENC_SHIFT   = 8;
  localparam int DECAY_SHIFT = 16;
  localparam int CORE_SHIFT  = 11;
  localparam int CHIP_SHIFT  = 16;
  localparam int TRACE_LSB   = DATA_W - TRACE_W;

  // Encoded input dimensions carried by the request (ports exist for two)
  localparam int INPUT_DIMENSIONS = 2;

  // Default population size
  localparam int NEURON_COUNT_DEF = 256;

  // Pipeline depth between request acceptance and the output register
  localparam int STAGE_COUNT = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_VOLTAGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FRACTION    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_VOLTAGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_NUMBER       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_NUMBER       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POPULATION_BASE   = 3'd6;

  // Configuration register set
  typedef struct packed {
    logic [DATA_W-1:0]  reset_voltage;
    logic [DECAY_W-1:0] decay_fraction;
    logic [DATA_W-1:0]  threshold_voltage;
    logic [REFR_W-1:0]  refractory_ticks;
    logic [CHIP_W-1:0]  chip_number;
    logic [CORE_W-1:0]  core_number;
    logic [POP_W-1:0]   population_base;
  } lifn_cfg_t;

  // Per-neuron state word
  typedef struct packed {
    logic [DATA_W-1:0] voltage;
    logic [REFR_W-1:0] refr;
  } lifn_state_t;

  // Stage load enables from the pipeline control
  typedef struct packed {
    logic [STAGE_COUNT:1] load;
    logic                 out_load;
  } lifn_ctrl_t;

endpackage

FILE: hdl/lifn_state_mem.sv
// ----------------------------------------------------------------------------
// lifn_state_mem
// Neuron state memory: one registered read port, one write port, and a
// clearing pass over every entry after reset.
// ----------------------------------------------------------------------------
module lifn_state_mem
  import lifn_pkg::*;
#(
  parameter int NEURON_COUNT = NEURON_COUNT_DEF,
  localparam int AddrW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output lifn_state_t      rd_data,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  lifn_state_t      wr_data,
  output logic             clr_busy
);

  lifn_state_t      mem [NEURON_COUNT];
  lifn_state_t      rd_data_r;
  logic             clr_busy_r;
  logic [AddrW-1:0] clr_addr_r;

  // Clearing pass: one entry per cycle from reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AddrW'(NEURON_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Write port, clearing takes priority
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

FILE: hdl/lifn_integrate.sv
// ----------------------------------------------------------------------------
// lifn_integrate
// Stages one to three: encoder products, input current sum, and the
// distance of the membrane voltage from its decay target.
// ----------------------------------------------------------------------------
module lifn_integrate
  import lifn_pkg::*;
(
  input  logic                      clk,
  input  lifn_ctrl_t                ctrl,
  input  lifn_cfg_t                 cfg,
  input  logic signed [DATA_W-1:0]  bias,
  input  logic signed [DATA_W-1:0]  encoder_first,
  input  logic signed [DATA_W-1:0]  encoder_second,
  input  logic signed [INPUT_W-1:0] input_first,
  input  logic signed [INPUT_W-1:0] input_second,
  input  lifn_state_t               s1_state,
  output logic [DATA_W-1:0]         s3_diff,
  output lifn_state_t               s3_state
);

  logic signed [DATA_W-1:0]  bias1_r, enc0_1_r, enc1_1_r;
  logic signed [INPUT_W-1:0] x0_1_r, x1_1_r;
  logic signed [PROD_W-1:0]  prod0_1, prod1_1;

  logic signed [PROD_W-1:0]  prod0_2_r, prod1_2_r;
  logic [DATA_W-1:0]         bias2_r;
  lifn_state_t               state2_r;
  logic [DATA_W-1:0]         term1_2;
  logic [DATA_W-1:0]         cur_2;

  logic [DATA_W-1:0]         cur3_r;
  lifn_state_t               state3_r;

  // Stage 1: capture the request
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      bias1_r  <= bias;
      enc0_1_r <= encoder_first;
      enc1_1_r <= encoder_second;
      x0_1_r   <= input_first;
      x1_1_r   <= input_second;
    end
  end

  // Encoder times input, one multiplier per dimension
  assign prod0_1 = PROD_W'(enc0_1_r) * PROD_W'(x0_1_r);
  assign prod1_1 = PROD_W'(enc1_1_r) * PROD_W'(x1_1_r);

  // Stage 2: products and fetched state
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      prod0_2_r <= prod0_1;
      prod1_2_r <= prod1_1;
      bias2_r   <= bias1_r;
      state2_r  <= s1_state;
    end
  end

  // Current = bias + sum of (product >>> 8), wrapping at 32 bits
  assign term1_2 = (INPUT_DIMENSIONS > 1) ? prod1_2_r[ENC_SHIFT +: DATA_W] : '0;
  assign cur_2   = bias2_r + prod0_2_r[ENC_SHIFT +: DATA_W] + term1_2;

  // Stage 3: current
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      cur3_r   <= cur_2;
      state3_r <= state2_r;
    end
  end

  // Distance to the decay target
  assign s3_diff  = cfg.reset_voltage - state3_r.voltage + cur3_r;
  assign s3_state = state3_r;

endmodule

FILE: hdl/lifn_leak_fire.sv
// ----------------------------------------------------------------------------
// lifn_leak_fire
// Stages four to six and the output register: leak multiply, voltage update
// and threshold test, spike handling and routing key.
// ----------------------------------------------------------------------------
module lifn_leak_fire
  import lifn_pkg::*;
(
  input  logic                      clk,
  input  lifn_ctrl_t                ctrl,
  input  lifn_cfg_t                 cfg,
  input  logic [DATA_W-1:0]         s3_diff,
  input  lifn_state_t               s3_state,
  input  logic [IDX_W-1:0]          s6_idx,
  output lifn_state_t               wb_state,
  output logic [IDX_W-1:0]          out_neuron_number,
  output logic                      out_spiked,
  output logic [DATA_W-1:0]         out_routing_key,
  output logic signed [TRACE_W-1:0] out_voltage_trace
);

  logic signed [DATA_W-1:0] diff4_r;
  lifn_state_t              state4_r;
  logic signed [PROD_W-1:0] leak_4;

  logic [DATA_W-1:0]        delta5_r;
  lifn_state_t              state5_r;
  logic [DATA_W-1:0]        vupd_5;
  logic                     fire_5;

  logic [DATA_W-1:0]        vupd6_r;
  logic [REFR_W-1:0]        refr6_r;
  logic                     fire6_r;
  logic [DATA_W-1:0]        vfin_6;
  logic [REFR_W-1:0]        refr_6;
  logic [DATA_W-1:0]        key_6;

  logic [IDX_W-1:0]         nn_r;
  logic                     spk_r;
  logic [DATA_W-1:0]        key_r;
  logic [TRACE_W-1:0]       trace_r;

  // Stage 4: leak multiply, fraction is unsigned
  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      diff4_r  <= s3_diff;
      state4_r <= s3_state;
    end
  end

  assign leak_4 = PROD_W'(diff4_r) * PROD_W'($signed({1'b0, cfg.decay_fraction}));

  // Stage 5: delta = product >>> 16
  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      delta5_r <= leak_4[DECAY_SHIFT +: DATA_W];
      state5_r <= state4_r;
    end
  end

  // Integrate only when not refractory; threshold test in every case
  assign vupd_5 = (state5_r.refr == '0) ? state5_r.voltage + delta5_r : state5_r.voltage;
  assign fire_5 = $signed(vupd_5) >= $signed(cfg.threshold_voltage);

  // Stage 6: spike handling
  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      vupd6_r <= vupd_5;
      refr6_r <= state5_r.refr;
      fire6_r <= fire_5;
    end
  end

  always_comb begin
    if (fire6_r) begin
      vfin_6 = cfg.reset_voltage + vupd6_r - cfg.threshold_voltage;
      refr_6 = cfg.refractory_ticks;
      key_6  = (DATA_W'(cfg.chip_number) << CHIP_SHIFT)
             | (DATA_W'(cfg.core_number) << CORE_SHIFT)
             | DATA_W'(cfg.population_base)
             | DATA_W'(s6_idx);
    end else begin
      vfin_6 = vupd6_r;
      refr_6 = (refr6_r == '0) ? refr6_r : refr6_r - 1'b1;
      key_6  = '0;
    end
  end

  assign wb_state.voltage = vfin_6;
  assign wb_state.refr    = refr_6;

  // Output register
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      nn_r    <= s6_idx;
      spk_r   <= fire6_r;
      key_r   <= key_6;
      trace_r <= vfin_6[TRACE_LSB +: TRACE_W];
    end
  end

  assign out_neuron_number = nn_r;
  assign out_spiked        = spk_r;
  assign out_routing_key   = key_r;
  assign out_voltage_trace = $signed(trace_r);

endmodule

FILE: hdl/lif_neuron_encoded_update.sv
// ----------------------------------------------------------------------------
// lif_neuron_encoded_update
// Leaky integrate-and-fire neuron update with two-dimensional encoded input.
// ----------------------------------------------------------------------------
// Each request updates one neuron and gives one result once it has passed the
// six register stages and then the output register. Requests for different
// neurons are taken one per cycle while out_stall does not back the pipeline
// up. The voltage update of a neuron depends on its previous one through the
// leak multiplier, so a request whose neuron (index modulo NEURON_COUNT) is
// still in one of the six stages is held with in_stall until that update has
// been written back. After reset the state memory is cleared one entry per
// cycle, with in_stall held high until the clearing pass ends; configuration
// writes are taken during that time.
// routing_key is zero on results without a spike.
// ----------------------------------------------------------------------------
module lif_neuron_encoded_update
  import lifn_pkg::*;
#(
  parameter int NEURON_COUNT = NEURON_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [IDX_W-1:0]             in_neuron_index,
  input  logic signed [DATA_W-1:0]     in_bias,
  input  logic signed [DATA_W-1:0]     in_encoder_first,
  input  logic signed [DATA_W-1:0]     in_encoder_second,
  input  logic signed [INPUT_W-1:0]    in_input_first,
  input  logic signed [INPUT_W-1:0]    in_input_second,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [IDX_W-1:0]             out_neuron_number,
  output logic                         out_spiked,
  output logic [DATA_W-1:0]            out_routing_key,
  output logic signed [TRACE_W-1:0]    out_voltage_trace
);

  localparam int AddrW   = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam int IdxVals = 2 ** IDX_W;

  lifn_cfg_t            cfg_r;
  lifn_ctrl_t           ctrl;

  logic [STAGE_COUNT:1] valid_r;
  logic                 out_valid_r;
  logic [AddrW-1:0]     slot_r [1:STAGE_COUNT];
  logic [IDX_W-1:0]     idx_r  [1:STAGE_COUNT];
  logic [STAGE_COUNT+1:1] can_move;

  logic [AddrW-1:0]     slot_lut [IdxVals];
  logic [AddrW-1:0]     in_slot;
  logic                 hazard;
  logic                 accept;
  logic                 clr_busy;

  lifn_state_t          s1_state;
  lifn_state_t          s3_state;
  lifn_state_t          wb_state;
  logic [DATA_W-1:0]    s3_diff;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RESET_VOLTAGE:     cfg_r.reset_voltage     <= cfg_data[DATA_W-1:0];
        CFG_DECAY_FRACTION:    cfg_r.decay_fraction    <= cfg_data[DECAY_W-1:0];
        CFG_THRESHOLD_VOLTAGE: cfg_r.threshold_voltage <= cfg_data[DATA_W-1:0];
        CFG_REFRACTORY_TICKS:  cfg_r.refractory_ticks  <= cfg_data[REFR_W-1:0];
        CFG_CHIP_NUMBER:       cfg_r.chip_number       <= cfg_data[CHIP_W-1:0];
        CFG_CORE_NUMBER:       cfg_r.core_number       <= cfg_data[CORE_W-1:0];
        CFG_POPULATION_BASE:   cfg_r.population_base   <= cfg_data[POP_W-1:0];
        default: ;
      endcase
    end
  end

  // Neuron index to memory slot, folded at elaboration
  for (genvar k = 0; k < IdxVals; k++) begin : g_slot
    localparam int SlotVal = k % NEURON_COUNT;
    assign slot_lut[k] = AddrW'(SlotVal);
  end
  assign in_slot = slot_lut[in_neuron_index];

  // Stage advance: a stage loads when empty or when its occupant moves on
  always_comb begin
    can_move[STAGE_COUNT+1] = !out_valid_r || !out_stall;
    for (int k = STAGE_COUNT; k >= 1; k--) begin
      can_move[k] = !valid_r[k] || can_move[k+1];
    end
  end

  assign ctrl.load     = can_move[STAGE_COUNT:1];
  assign ctrl.out_load = can_move[STAGE_COUNT+1];

  // Same neuron still in flight: hold until written back
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= STAGE_COUNT; k++) begin
      hazard = hazard | (valid_r[k] && (slot_r[k] == in_slot));
    end
  end

  assign in_stall = !can_move[1] || hazard || clr_busy;
  assign accept   = in_valid && !in_stall;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (can_move[1]) begin
        valid_r[1] <= accept;
      end
      for (int k = 2; k <= STAGE_COUNT; k++) begin
        if (can_move[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
      if (can_move[STAGE_COUNT+1]) begin
        out_valid_r <= valid_r[STAGE_COUNT];
      end
    end
  end

  // Slot and index travel with the request
  always_ff @(posedge clk) begin
    if (can_move[1]) begin
      slot_r[1] <= in_slot;
      idx_r[1]  <= in_neuron_index;
    end
    for (int k = 2; k <= STAGE_COUNT; k++) begin
      if (can_move[k]) begin
        slot_r[k] <= slot_r[k-1];
        idx_r[k]  <= idx_r[k-1];
      end
    end
  end

  lifn_state_mem #(
    .NEURON_COUNT (NEURON_COUNT)
  ) u_state_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (can_move[1]),
    .rd_addr  (in_slot),
    .rd_data  (s1_state),
    .wr_en    (can_move[STAGE_COUNT+1] && valid_r[STAGE_COUNT]),
    .wr_addr  (slot_r[STAGE_COUNT]),
    .wr_data  (wb_state),
    .clr_busy (clr_busy)
  );

  lifn_integrate u_integrate (
    .clk            (clk),
    .ctrl           (ctrl),
    .cfg            (cfg_r),
    .bias           (in_bias),
    .encoder_first  (in_encoder_first),
    .encoder_second (in_encoder_second),
    .input_first    (in_input_first),
    .input_second   (in_input_second),
    .s1_state       (s1_state),
    .s3_diff        (s3_diff),
    .s3_state       (s3_state)
  );

  lifn_leak_fire u_leak_fire (
    .clk               (clk),
    .ctrl              (ctrl),
    .cfg               (cfg_r),
    .s3_diff           (s3_diff),
    .s3_state          (s3_state),
    .s6_idx            (idx_r[STAGE_COUNT]),
    .wb_state          (wb_state),
    .out_neuron_number (out_neuron_number),
    .out_spiked        (out_spiked),
    .out_routing_key   (out_routing_key),
    .out_voltage_trace (out_voltage_trace)
  );

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/lifn_checker.sv
// ----------------------------------------------------------------------------
// lifn_checker
// Port-level checks on the neuron update block, bound to the top level.
// ----------------------------------------------------------------------------
module lifn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_neuron_number,
  input logic        out_spiked,
  input logic [31:0] out_routing_key,
  input logic [15:0] out_voltage_trace
);

  // Held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neuron_number)
      && $stable(out_spiked) && $stable(out_routing_key) && $stable(out_voltage_trace))
    else $error("result changed while stalled");

  // No key without a spike
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_spiked |-> out_routing_key == 32'h0)
    else $error("routing key set without spike");

  // Neuron number bits always present in a spike key
  a_key_neuron: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_spiked |-> (out_routing_key[7:0] & out_neuron_number) == out_neuron_number)
    else $error("routing key lacks neuron number");

  // State clearing holds off requests straight after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during state clearing");

endmodule

bind lif_neuron_encoded_update lifn_checker u_lifn_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_neuron_number (out_neuron_number),
  .out_spiked        (out_spiked),
  .out_routing_key   (out_routing_key),
  .out_voltage_trace (out_voltage_trace)
);

FILE: tb/tb_lif_neuron_encoded_update.sv
// ----------------------------------------------------------------------------
// tb_lif_neuron_encoded_update
// Self-checking bench for the encoded LIF neuron update. A table of directed
// requests runs first, then random phases under changing register settings.
// Every accepted request is run through a local neuron model. Each result is
// checked field by field against the oldest outstanding expected result. The
// sender works in bursts and the receiver stalls on its own pattern, with
// long hold-offs that back the pipeline up.
// ----------------------------------------------------------------------------
module tb_lif_neuron_encoded_update;
  timeunit 1ns;
  timeprecision 1ps;

  import lifn_pkg::*;

  localparam int N_NEURONS   = NEURON_COUNT_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_REQS  = 190;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DIR_ROWS    = 34;
  localparam int MAX_PRINTS  = 50;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [DATA_W-1:0]  bias;
    logic signed [DATA_W-1:0]  enc0;
    logic signed [DATA_W-1:0]  enc1;
    logic signed [INPUT_W-1:0] x0;
    logic signed [INPUT_W-1:0] x1;
  } neuron_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]          nrn;
    logic                      spk;
    logic [DATA_W-1:0]         key;
    logic signed [TRACE_W-1:0] trace;
  } neuron_res_t;

  // request waiting for the sender, with an optional fixed expectation
  typedef struct packed {
    neuron_req_t req;
    logic        typed;
    neuron_res_t res;
  } pending_req_t;

  typedef enum logic {ROW_REG, ROW_REQ} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    neuron_req_t           req;
    logic                  typed;
    neuron_res_t           res;
  } dir_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [IDX_W-1:0]             in_neuron_index;
  logic signed [DATA_W-1:0]     in_bias;
  logic signed [DATA_W-1:0]     in_encoder_first;
  logic signed [DATA_W-1:0]     in_encoder_second;
  logic signed [INPUT_W-1:0]    in_input_first;
  logic signed [INPUT_W-1:0]    in_input_second;
  logic                         out_valid;
  logic                         out_stall;
  logic [IDX_W-1:0]             out_neuron_number;
  logic                         out_spiked;
  logic [DATA_W-1:0]            out_routing_key;
  logic signed [TRACE_W-1:0]    out_voltage_trace;

  // local copy of the neuron state and registers
  logic [DATA_W-1:0]  v_mem    [N_NEURONS];
  logic [REFR_W-1:0]  refr_mem [N_NEURONS];
  logic [DATA_W-1:0]  rest_v;
  logic [DECAY_W-1:0] leak;
  logic [DATA_W-1:0]  thresh;
  logic [REFR_W-1:0]  refr_ticks;
  logic [CHIP_W-1:0]  chip_id;
  logic [CORE_W-1:0]  core_id;
  logic [POP_W-1:0]   pop_base;

  pending_req_t request_q [$];
  neuron_res_t  due_results [$];
  neuron_res_t  oldest;
  dir_row_t     dir_tab [DIR_ROWS];

  int  queued_cnt    = 0;
  int  accepted_cnt  = 0;
  int  results_seen  = 0;
  int  spikes_seen   = 0;
  int  err_count     = 0;
  int  backpressure  = 0;
  int  holds_done    = 0;
  int  settings_used = 0;
  int  cycle_count   = 0;
  bit  hold_req      = 1'b0;

  lif_neuron_encoded_update u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_neuron_index   (in_neuron_index),
    .in_bias           (in_bias),
    .in_encoder_first  (in_encoder_first),
    .in_encoder_second (in_encoder_second),
    .in_input_first    (in_input_first),
    .in_input_second   (in_input_second),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_neuron_number (out_neuron_number),
    .out_spiked        (out_spiked),
    .out_routing_key   (out_routing_key),
    .out_voltage_trace (out_voltage_trace)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lif_neuron_encoded_update test failed");
    $finish;
  end

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t ERROR %s", $realtime, msg);
  endtask

  // register write into the local copy, masked to each register's width
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
    case (i)
      CFG_RESET_VOLTAGE:     rest_v     = d;
      CFG_DECAY_FRACTION:    leak       = d[DECAY_W-1:0];
      CFG_THRESHOLD_VOLTAGE: thresh     = d;
      CFG_REFRACTORY_TICKS:  refr_ticks = d[REFR_W-1:0];
      CFG_CHIP_NUMBER:       chip_id    = d[CHIP_W-1:0];
      CFG_CORE_NUMBER:       core_id    = d[CORE_W-1:0];
      CFG_POPULATION_BASE:   pop_base   = d[POP_W-1:0];
      default: ;
    endcase
  endfunction

  // one tick of one neuron: leak toward rest plus current, fire, refractory
  function automatic neuron_res_t neuron_update(neuron_req_t r);
    neuron_res_t res;
    int          slot;
    logic [31:0] v, cur, diff;
    longint      enc, x, term, dv, dl, delta;
    slot = int'(r.idx) % N_NEURONS;
    v    = v_mem[slot];
    res  = '0;
    if (refr_mem[slot] == '0) begin
      cur  = r.bias;
      enc  = longint'($signed(r.enc0));
      x    = longint'($signed(r.x0));
      term = (enc * x) >>> ENC_SHIFT;
      cur += 32'(term);
      enc  = longint'($signed(r.enc1));
      x    = longint'($signed(r.x1));
      term = (enc * x) >>> ENC_SHIFT;
      cur += 32'(term);
      diff  = rest_v - v + cur;
      dv    = longint'($signed(diff));
      dl    = longint'(leak);
      delta = (dv * dl) >>> DECAY_SHIFT;
      v    += 32'(delta);
    end else begin
      refr_mem[slot] = refr_mem[slot] - 16'd1;
    end
    // threshold is tested even while refractory
    if ($signed(v) >= $signed(thresh)) begin
      res.spk = 1'b1;
      res.key = (32'(chip_id) << CHIP_SHIFT) | (32'(core_id) << CORE_SHIFT) |
                32'(pop_base) | 32'(r.idx);
      v = rest_v + v - thresh;
      refr_mem[slot] = refr_ticks;
    end
    v_mem[slot] = v;
    res.nrn   = r.idx;
    res.trace = v[DATA_W-1:TRACE_LSB];
    return res;
  endfunction

  // table row builders
  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
    dir_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_idx = i;
    r.reg_val = d;
    return r;
  endfunction

  function automatic dir_row_t req_row(logic [7:0] idx, logic [31:0] b, e0, e1,
                                       logic [15:0] x0, x1);
    dir_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.req  = '{idx, b, e0, e1, x0, x1};
    return r;
  endfunction

  function automatic dir_row_t chk_row(logic [7:0] idx, logic [31:0] b, e0, e1,
                                       logic [15:0] x0, x1, logic spk,
                                       logic [31:0] key, logic [15:0] trace);
    dir_row_t r;
    r       = req_row(idx, b, e0, e1, x0, x1);
    r.typed = 1'b1;
    r.res   = '{idx, spk, key, trace};
    return r;
  endfunction

  task automatic queue_request(input neuron_req_t rq, input logic typed, input neuron_res_t rs);
    request_q.push_back('{rq, typed, rs});
    queued_cnt++;
  endtask

  // random request: tame values keep voltages near threshold, wild ones span everything
  function automatic neuron_req_t random_request(bit wild, int base);
    neuron_req_t r;
    if ($urandom_range(0, 99) < 40) r.idx = 8'(base + int'($urandom_range(0, 3)));
    else r.idx = 8'($urandom_range(0, N_NEURONS - 1));
    if (wild) begin
      r.bias = $urandom;
      r.enc0 = $urandom;
      r.enc1 = $urandom;
      r.x0   = 16'($urandom);
      r.x1   = 16'($urandom);
    end else begin
      r.bias = $signed($urandom_range(0, 2097151)) - 1048576;
      r.enc0 = $signed($urandom_range(0, 131070)) - 65535;
      r.enc1 = $signed($urandom_range(0, 131070)) - 65535;
      r.x0   = 16'($signed($urandom_range(0, 8190)) - 4095);
      r.x1   = 16'($signed($urandom_range(0, 8190)) - 4095);
    end
    return r;
  endfunction

  // nothing queued, nothing in flight
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] i, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= i;
    cfg_data  <= d;
    apply_reg(i, d);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_neuron_config(input logic [31:0] rest, dec, thr, ticks, chip, core, pop);
    wait_idle();
    write_reg(CFG_RESET_VOLTAGE, rest);
    write_reg(CFG_DECAY_FRACTION, dec);
    write_reg(CFG_THRESHOLD_VOLTAGE, thr);
    write_reg(CFG_REFRACTORY_TICKS, ticks);
    write_reg(CFG_CHIP_NUMBER, chip);
    write_reg(CFG_CORE_NUMBER, core);
    write_reg(CFG_POPULATION_BASE, pop);
    write_reg(CFG_UNUSED, $urandom);
    settings_used++;
  endtask

  // request sender: bursts of random length, random gaps, predicts on acceptance
  initial begin : sender
    pending_req_t cur_item;
    neuron_res_t  predicted;
    int           burst_left;
    int           gap_left;
    burst_left = 0;
    gap_left   = 0;
    cur_item   = '0;
    in_valid          <= 1'b0;
    in_neuron_index   <= '0;
    in_bias           <= '0;
    in_encoder_first  <= '0;
    in_encoder_second <= '0;
    in_input_first    <= '0;
    in_input_second   <= '0;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        predicted = neuron_update(cur_item.req);
        due_results.push_back(cur_item.typed ? cur_item.res : predicted);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_item = request_q.pop_front();
          in_valid          <= 1'b1;
          in_neuron_index   <= cur_item.req.idx;
          in_bias           <= cur_item.req.bias;
          in_encoder_first  <= cur_item.req.enc0;
          in_encoder_second <= cur_item.req.enc1;
          in_input_first    <= cur_item.req.x0;
          in_input_second   <= cur_item.req.x1;
          burst_left--;
          if (burst_left <= 0) begin
            // now and then a long burst with no gap after it
            if ($urandom_range(0, 9) == 0) begin
              burst_left = 150;
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 40);
              gap_left   = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 6);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall pattern changes at random intervals, plus long hold-offs
  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          period;
    int          hold_left;
    mode      = STALL_NONE;
    mode_left = 0;
    period    = 3;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
          period    = $urandom_range(2, 5);
        end
        mode_left--;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
          STALL_PERIODIC: out_stall <= (mode_left % period == 0);
          default:        out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) backpressure++;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_spiked) spikes_seen++;
      if (due_results.size() == 0) begin
        report_error($sformatf("result for neuron %0d with nothing outstanding",
                               out_neuron_number));
      end else begin
        oldest = due_results.pop_front();
        if (out_neuron_number !== oldest.nrn)
          report_error($sformatf("neuron_number got %0d want %0d",
                                 out_neuron_number, oldest.nrn));
        if (out_spiked !== oldest.spk)
          report_error($sformatf("spiked on neuron %0d got %b want %b",
                                 oldest.nrn, out_spiked, oldest.spk));
        if (out_routing_key !== oldest.key)
          report_error($sformatf("routing_key on neuron %0d got %h want %h",
                                 oldest.nrn, out_routing_key, oldest.key));
        if (out_voltage_trace !== oldest.trace)
          report_error($sformatf("voltage_trace on neuron %0d got %h want %h",
                                 oldest.nrn, out_voltage_trace, oldest.trace));
      end
    end
  end

  // main sequence
  initial begin : main
    logic [31:0] rest;
    logic [31:0] thr;
    int          wild_pct;
    int          base;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (int n = 0; n < N_NEURONS; n++) begin
      v_mem[n]    = '0;
      refr_mem[n] = '0;
    end
    rest_v     = '0;
    leak       = '0;
    thresh     = '0;
    refr_ticks = '0;
    chip_id    = '0;
    core_id    = '0;
    pop_base   = '0;

    // directed table; with all registers at zero every neuron fires and stays at zero
    dir_tab = '{
      chk_row(8'h00, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
              1'b1, 32'h00000000, 16'h0000),
      chk_row(8'hFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF,
              1'b1, 32'h000000FF, 16'h0000),
      chk_row(8'h55, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555,
              1'b1, 32'h00000055, 16'h0000),
      chk_row(8'hAA, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA,
              1'b1, 32'h000000AA, 16'h0000),
      chk_row(8'hFF, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 32'h000000FF, 16'h0000),
      // full leak, unreachable threshold; index seven is ignored
      reg_row(CFG_DECAY_FRACTION, 32'h0000FFFF),
      reg_row(CFG_THRESHOLD_VOLTAGE, 32'h7FFFFFFF),
      reg_row(CFG_UNUSED, 32'hFFFFFFFF),
      req_row(8'h01, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF),
      req_row(8'h01, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 16'h8000),
      req_row(8'h02, 32'h00010000, 32'hFFFFFF00, 32'h00000100, 16'hFFFF, 16'h0001),
      req_row(8'h02, 32'hFFFFFFFF, 32'h00000001, 32'h00000001, 16'hFFFF, 16'hFFFF),
      // no spike: key must read zero
      chk_row(8'h10, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 32'h00000000, 16'h0000),
      // lowest threshold, no leak, all key fields full (wide writes are masked)
      reg_row(CFG_THRESHOLD_VOLTAGE, 32'h80000000),
      reg_row(CFG_DECAY_FRACTION, 32'h00000000),
      reg_row(CFG_REFRACTORY_TICKS, 32'h00000003),
      reg_row(CFG_CHIP_NUMBER, 32'hFFFFFFFF),
      reg_row(CFG_CORE_NUMBER, 32'hFFFFFFFF),
      reg_row(CFG_POPULATION_BASE, 32'hFFFFFFFF),
      chk_row(8'h20, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 32'hFFFFFFFF, 16'h8000),
      // refractory neuron still at threshold fires again
      chk_row(8'h20, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 32'hFFFFFFFF, 16'h0000),
      // population bits overlap the neuron index
      reg_row(CFG_POPULATION_BASE, 32'h000000F0),
      reg_row(CFG_RESET_VOLTAGE, 32'h7FFFFFFF),
      reg_row(CFG_CHIP_NUMBER, 32'h00000000),
      reg_row(CFG_CORE_NUMBER, 32'h00000000),
      chk_row(8'h3C, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 32'h000000FC, 16'hFFFF),
      req_row(8'h3C, 32'h00400000, 32'h00001000, 32'hFFFFF000, 16'h0100, 16'h0200),
      // lowest rest, half leak, long refractory
      reg_row(CFG_RESET_VOLTAGE, 32'h80000000),
      reg_row(CFG_DECAY_FRACTION, 32'h00008000),
      reg_row(CFG_THRESHOLD_VOLTAGE, 32'h00000000),
      reg_row(CFG_REFRACTORY_TICKS, 32'h0000FFFF),
      req_row(8'h40, 32'h12345678, 32'hFFFF0000, 32'h0000FFFF, 16'h1234, 16'hEDCB),
      req_row(8'h40, 32'h7FFFFFFF, 32'h00010000, 32'hFFFF0000, 16'h7FFF, 16'h8000),
      req_row(8'h80, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'h0001, 16'hFFFF)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        queue_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
      end
    end
    settings_used++;

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wild_pct = 20;
      case (p)
        1: begin
          set_neuron_config(32'h80000000, 32'h0000FFFF, 32'h7FFFFFFF, 32'h0000FFFF,
                            32'h0000FFFF, 32'h0000001F, 32'h000007FF);
          wild_pct = 70;
        end
        2: set_neuron_config(32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0);
        5: begin
          set_neuron_config($urandom, $urandom, $urandom, $urandom_range(0, 3),
                            $urandom, $urandom, $urandom);
          wild_pct = 70;
        end
        default: begin
          rest = $signed($urandom_range(0, 131072)) - 65536;
          thr  = rest + $urandom_range(32'h40000, 32'h200000);
          set_neuron_config(rest, $urandom_range(0, 65535), thr, $urandom_range(0, 6),
                            $urandom_range(0, 65535), $urandom_range(0, 31),
                            $urandom_range(0, 2047));
        end
      endcase
      // back the pipeline up while requests keep coming
      if (p == 0 || p == 4) hold_req = 1'b1;
      base = $urandom_range(0, N_NEURONS - 1);
      for (int k = 0; k < PHASE_REQS; k++)
        queue_request(random_request($urandom_range(0, 99) < wild_pct, base), 1'b0, '0);
    end

    wait_idle();
    repeat (4 * STAGE_COUNT) @(posedge clk);

    $display("Covered %0d neuron updates under %0d register settings, %0d of them spikes.",
             accepted_cnt, settings_used, spikes_seen);
    $display("Input was held back for %0d cycles, output held off %0d times.",
             backpressure, holds_done);
    if (err_count == 0 && due_results.size() == 0) begin
      $display("lif_neuron_encoded_update test passed");
    end else begin
      $display("lif_neuron_encoded_update test failed");
    end
    $finish;
  end

endmodule
